@@ design/fcsl_pkg.sv @@
// ---------------------------------------------------------------------------
// Fog color slew limiter package
// State encoding, register indexes, biome codes and the target color helper.
// ---------------------------------------------------------------------------
package fcsl_pkg;

	// Sequencer states, one-hot.
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SQ   = 6'b000010,
		ST_ROOT = 6'b000100,
		ST_MUL  = 6'b001000,
		ST_DIV  = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	// Configuration register indexes.
	localparam logic REG_FOG_ENABLE       = 1'b0;
	localparam logic REG_TRANSITION_SPEED = 1'b1;

	// Reset values of the configuration registers.
	localparam logic        FOG_ENABLE_RST       = 1'b1;
	localparam logic [15:0] TRANSITION_SPEED_RST = 16'd4096;

	// Biome codes carried by a frame.
	localparam logic [1:0] BIOME_MEADOW   = 2'd0;
	localparam logic [1:0] BIOME_HIGHLAND = 2'd1;
	localparam logic [1:0] BIOME_WOODLAND = 2'd2;
	localparam logic [1:0] BIOME_DEFAULT  = 2'd3;

	// Target levels in thousandths, per biome and channel.
	localparam int unsigned MILLI_FIELD_R     = 400;
	localparam int unsigned MILLI_FIELD_G     = 250;
	localparam int unsigned MILLI_FIELD_B     = 150;
	localparam int unsigned MILLI_MOUNTAIN_R  = 50;
	localparam int unsigned MILLI_MOUNTAIN_G  = 50;
	localparam int unsigned MILLI_MOUNTAIN_B  = 150;
	localparam int unsigned MILLI_FOREST_R    = 400;
	localparam int unsigned MILLI_FOREST_G    = 450;
	localparam int unsigned MILLI_FOREST_B    = 500;
	localparam int unsigned MILLI_DEFAULT_R   = 50;
	localparam int unsigned MILLI_DEFAULT_G   = 50;
	localparam int unsigned MILLI_DEFAULT_B   = 150;

	// Converts thousandths to an unsigned fraction of the given width, rounded
	// to nearest and clamped to full scale. Evaluated at elaboration only.
	function automatic int unsigned target_level(int unsigned milli, int unsigned bits);
		longint unsigned v;
		longint unsigned r;
		longint unsigned full;
		v = longint'(milli) << bits;
		r = (v + 64'd500) / 64'd1000;
		full = (64'd1 << bits) - 64'd1;
		return (r > full) ? int'(full) : int'(r);
	endfunction

endpackage

@@ design/fog_color_slew_limiter.sv @@
// ---------------------------------------------------------------------------
// Fog color slew limiter
// Moves the fog color toward a biome target at a limited rate per frame.
// ---------------------------------------------------------------------------
// Usage:
// One input transfer per frame carries the biome code and the frame time. The
// block answers each one with exactly one output transfer holding the fog color
// after the step and a settled flag. Input ready is high only while the
// sequencer is idle, so one item is worked on at a time.
// When the color moves, the shared trial subtractor takes the square root in
// COLOUR_BITS+1 steps and then divides each of the three channels in turn; each
// division follows one multiply and resolves COLOUR_BITS quotient bits in as
// many steps. When the color snaps or holds, only the square root runs, and
// when fog is disabled the sequencer goes from the step size straight to the
// final state. One shared multiplier forms the squares, the step size and the
// scaled moves. The sequencer returns to idle as a result is registered and
// then accepts the next item. Results sit in an output register, so a new item
// is accepted while an old result waits; when the receiver stalls, a finished
// item waits in the final state until the output register frees up. Reset
// restores the default color and the register reset values. Configuration
// writes take effect at once.
// ---------------------------------------------------------------------------
module fog_color_slew_limiter #(
	parameter int unsigned COLOUR_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic                   cfg_index,
	input  logic [15:0]            cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             biome,
	input  logic [15:0]            delta_time,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [COLOUR_BITS-1:0] fog_red,
	output logic [COLOUR_BITS-1:0] fog_green,
	output logic [COLOUR_BITS-1:0] fog_blue,
	output logic                   settled
);
	import fcsl_pkg::*;

	localparam int unsigned CB   = COLOUR_BITS;
	// Length and step width; the squared length and the trial remainder.
	localparam int unsigned LW   = CB + 1;
	localparam int unsigned SQW  = 2 * CB + 2;
	localparam int unsigned RW   = CB + 3;
	// Multiplier operand width covers the 16-bit speed and time as well.
	localparam int unsigned MW   = (LW > 16) ? LW : 16;
	localparam int unsigned PW   = 2 * MW;
	localparam int unsigned CNTW = $clog2(LW);

	localparam logic [LW-1:0] SNAP_LIMIT = LW'((2 ** CB) / 1000);
	localparam logic [LW-1:0] STEP_MAX   = LW'((2 ** (CB + 1)) - 1);

	// Target colors, indexed by biome code and then channel.
	localparam logic [CB-1:0] TGT [4][3] = '{
		'{CB'(target_level(MILLI_FIELD_R, CB)), CB'(target_level(MILLI_FIELD_G, CB)),
		  CB'(target_level(MILLI_FIELD_B, CB))},
		'{CB'(target_level(MILLI_MOUNTAIN_R, CB)), CB'(target_level(MILLI_MOUNTAIN_G, CB)),
		  CB'(target_level(MILLI_MOUNTAIN_B, CB))},
		'{CB'(target_level(MILLI_FOREST_R, CB)), CB'(target_level(MILLI_FOREST_G, CB)),
		  CB'(target_level(MILLI_FOREST_B, CB))},
		'{CB'(target_level(MILLI_DEFAULT_R, CB)), CB'(target_level(MILLI_DEFAULT_G, CB)),
		  CB'(target_level(MILLI_DEFAULT_B, CB))}
	};

	state_t               state_q;
	logic                 fog_enable_q;
	logic [15:0]          transition_speed_q;
	logic [1:0]           biome_q;
	logic [15:0]          dt_q;
	logic signed [CB:0]   diff_q [3];
	logic [CB-1:0]        cur_q [3];
	logic [1:0]           ch_q;
	logic [CNTW-1:0]      cnt_q;
	logic [SQW-1:0]       sq_q;
	logic [SQW-1:0]       src_q;
	logic [RW-1:0]        rem_q;
	logic [LW-1:0]        res_q;
	logic [LW-1:0]        step_q;
	// The divisor is the length, kept in its own register.
	logic [LW-1:0]        len_q;
	logic                 out_valid_q;
	logic [CB-1:0]        out_col_q [3];
	logic                 settled_q;

	// Channel magnitudes of the difference vector.
	logic [CB-1:0]        mag [3];
	logic signed [CB:0]   diff_new [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			logic signed [CB:0] neg;
			neg = -diff_q[c];
			mag[c] = diff_q[c][CB] ? neg[CB-1:0] : diff_q[c][CB-1:0];
			diff_new[c] = $signed({1'b0, TGT[biome][c]}) - $signed({1'b0, cur_q[c]});
		end
	end

	// Shared multiplier: squares, speed times time, and magnitude times step.
	logic [MW-1:0] mul_a;
	logic [MW-1:0] mul_b;
	logic [PW-1:0] prod;
	logic [PW-1:0] step_raw;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SQ: begin
				if (ch_q == 2'd3) begin
					mul_a = MW'(transition_speed_q);
					mul_b = MW'(dt_q);
				end else begin
					mul_a = MW'(mag[ch_q]);
					mul_b = MW'(mag[ch_q]);
				end
			end
			ST_MUL: begin
				mul_a = MW'(mag[ch_q]);
				mul_b = MW'(step_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod     = mul_a * mul_b;
	assign step_raw = prod >> 16;

	// Shared trial subtractor: two radicand bits per square root step, one
	// dividend bit per division step.
	logic [RW-1:0] shifted;
	logic [RW-1:0] trial;
	logic [RW:0]   trial_diff;
	logic          ge;
	logic [RW-1:0] rem_next;
	logic [LW-1:0] res_next;

	always_comb begin
		case (state_q)
			ST_ROOT: begin
				shifted = {rem_q[RW-3:0], src_q[SQW-1:SQW-2]};
				trial   = {res_q, 2'b01};
			end
			ST_DIV: begin
				shifted = {rem_q[RW-2:0], src_q[SQW-1]};
				trial   = {2'b00, len_q};
			end
			default: begin
				shifted = '0;
				trial   = '0;
			end
		endcase
	end

	assign trial_diff = {1'b0, shifted} - {1'b0, trial};
	assign ge         = ~trial_diff[RW];
	assign rem_next   = ge ? trial_diff[RW-1:0] : shifted;
	assign res_next   = {res_q[LW-2:0], ge};

	assign in_ready = (state_q == ST_IDLE);

	// A finished item moves into the output register once that register is
	// empty or being emptied in the same cycle.
	logic out_load;

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q            <= ST_IDLE;
			fog_enable_q       <= FOG_ENABLE_RST;
			transition_speed_q <= TRANSITION_SPEED_RST;
			out_valid_q        <= 1'b0;
			ch_q               <= '0;
			cnt_q              <= '0;
			for (int c = 0; c < 3; c++) begin
				cur_q[c] <= TGT[BIOME_DEFAULT][c];
			end
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_FOG_ENABLE:       fog_enable_q <= cfg_data[0];
					REG_TRANSITION_SPEED: transition_speed_q <= cfg_data;
					default: begin
					end
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						biome_q <= biome;
						dt_q    <= delta_time;
						for (int c = 0; c < 3; c++) begin
							diff_q[c] <= diff_new[c];
						end
						sq_q    <= '0;
						ch_q    <= '0;
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					// Three squares accumulate, then the step size is formed.
					if (ch_q == 2'd3) begin
						step_q  <= (step_raw > PW'(STEP_MAX)) ? STEP_MAX : step_raw[LW-1:0];
						src_q   <= sq_q;
						rem_q   <= '0;
						res_q   <= '0;
						cnt_q   <= '0;
						ch_q    <= '0;
						state_q <= fog_enable_q ? ST_ROOT : ST_DONE;
					end else begin
						sq_q <= sq_q + SQW'(prod);
						ch_q <= ch_q + 2'd1;
					end
				end
				ST_ROOT: begin
					src_q <= {src_q[SQW-3:0], 2'b00};
					rem_q <= rem_next;
					res_q <= res_next;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNTW'(LW - 1)) begin
						len_q <= res_next;
						if (res_next > SNAP_LIMIT) begin
							if (res_next > step_q) begin
								ch_q    <= '0;
								state_q <= ST_MUL;
							end else begin
								// Within one step of the target: snap onto it.
								for (int c = 0; c < 3; c++) begin
									cur_q[c] <= TGT[biome_q][c];
								end
								state_q <= ST_DONE;
							end
						end else begin
							// A tiny nonzero difference is left alone.
							state_q <= ST_DONE;
						end
					end
				end
				ST_MUL: begin
					// The top bits of the product are known to be below the length,
					// so the division only has to resolve COLOUR_BITS quotient bits.
					rem_q   <= RW'(prod[2*CB:CB]);
					src_q   <= {prod[CB-1:0], {(SQW - CB){1'b0}}};
					res_q   <= '0;
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					src_q <= {src_q[SQW-2:0], 1'b0};
					rem_q <= rem_next;
					res_q <= res_next;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNTW'(CB - 1)) begin
						// The move is smaller than the difference, so no clamp is needed.
						if (diff_q[ch_q][CB]) begin
							cur_q[ch_q] <= cur_q[ch_q] - res_next[CB-1:0];
						end else begin
							cur_q[ch_q] <= cur_q[ch_q] + res_next[CB-1:0];
						end
						if (ch_q == 2'd2) begin
							state_q <= ST_DONE;
						end else begin
							ch_q    <= ch_q + 2'd1;
							state_q <= ST_MUL;
						end
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output payload, loaded as the final state hands off its result.
	always_ff @(posedge clk) begin
		if (out_load) begin
			for (int c = 0; c < 3; c++) begin
				out_col_q[c] <= cur_q[c];
			end
			settled_q <= (cur_q[0] == TGT[biome_q][0]) && (cur_q[1] == TGT[biome_q][1]) &&
				(cur_q[2] == TGT[biome_q][2]);
		end
	end

	assign out_valid = out_valid_q;
	assign fog_red   = out_col_q[0];
	assign fog_green = out_col_q[1];
	assign fog_blue  = out_col_q[2];
	assign settled   = settled_q;

endmodule
